>>> design/msi_pkg.sv
// ----------------------------------------------------------------------------
// msi_pkg: shared types and constants for the motion safety interlock.
// Holds the event codes, the one-hot mode encoding and the item structs.
// ----------------------------------------------------------------------------
package msi_pkg;

  // Width of the fault fields carried on the ports.
  localparam int unsigned FIELD_W = 8;

  // Default width of the latched fault mask.
  localparam int unsigned FAULT_BITS_DEF = 8;

  // Event codes.
  typedef enum logic [2:0] {
    OP_BOOT_DONE    = 3'd0,
    OP_ARM          = 3'd1,
    OP_DISARM       = 3'd2,
    OP_MOTION_START = 3'd3,
    OP_MOTION_STOP  = 3'd4,
    OP_RAISE_FAULT  = 3'd5,
    OP_ESTOP        = 3'd6,
    OP_CLEAR        = 3'd7
  } op_t;

  // Interlock state, one-hot.
  typedef enum logic [5:0] {
    MODE_BOOT    = 6'b000001,
    MODE_SAFE    = 6'b000010,
    MODE_READY   = 6'b000100,
    MODE_RUNNING = 6'b001000,
    MODE_FAULT   = 6'b010000,
    MODE_ESTOP   = 6'b100000
  } mode_t;

  // Mode numbers as reported on the result channel.
  localparam logic [2:0] MODE_CODE_BOOT    = 3'd0;
  localparam logic [2:0] MODE_CODE_SAFE    = 3'd1;
  localparam logic [2:0] MODE_CODE_READY   = 3'd2;
  localparam logic [2:0] MODE_CODE_RUNNING = 3'd3;
  localparam logic [2:0] MODE_CODE_FAULT   = 3'd4;
  localparam logic [2:0] MODE_CODE_ESTOP   = 3'd5;

  // Event status codes.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef struct packed {
    op_t                operation;
    logic [FIELD_W-1:0] raise_faults;
    logic [FIELD_W-1:0] live_faults;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic [2:0]         mode_now;
    logic [FIELD_W-1:0] faults_now;
    logic               estop_now;
    logic               armed;
    logic               motion_allowed;
  } out_item_t;

  // Converts the one-hot state into its reported number.
  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] code;
    case (m)
      MODE_BOOT:    code = MODE_CODE_BOOT;
      MODE_SAFE:    code = MODE_CODE_SAFE;
      MODE_READY:   code = MODE_CODE_READY;
      MODE_RUNNING: code = MODE_CODE_RUNNING;
      MODE_FAULT:   code = MODE_CODE_FAULT;
      MODE_ESTOP:   code = MODE_CODE_ESTOP;
      default:      code = MODE_CODE_BOOT;
    endcase
    return code;
  endfunction

endpackage

>>> design/motion_safety_interlock_fsm_core.sv
// ----------------------------------------------------------------------------
// motion_safety_interlock_fsm_core: six-state motion safety interlock.
// The result of an event is registered and valid in the cycle after it is accepted.
// Throughput: one event per cycle while the output is not stalled, limited by the single output register.
// Reset: synchronous active-low; state boot, fault mask and estop latch clear.
// ----------------------------------------------------------------------------
module motion_safety_interlock_fsm_core
  import msi_pkg::*;
#(
  parameter int unsigned FaultBits = FAULT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // The interlock state lives in three registers. Each accepted event is
  // decoded against them in one pass of combinational logic; the new state
  // is written back and the snapshot after the event lands in the output
  // register in the same clock edge.
  mode_t                mode_r;
  mode_t                mode_nxt;
  logic [FaultBits-1:0] fault_r;
  logic [FaultBits-1:0] fault_nxt;
  logic                 estop_r;
  logic                 estop_nxt;

  logic                 out_valid_r;
  logic                 out_valid_nxt;
  out_item_t            out_data_r;
  out_item_t            result;

  logic                 in_accept;
  logic                 bad;
  logic                 armed;
  logic                 fault_empty;
  logic [FaultBits-1:0] raise_w;
  logic [FaultBits-1:0] live_w;
  logic [FIELD_W-1:0]   faults_view;

  // The output register is the only buffer. A new event is taken whenever
  // that register is empty or is being drained in this same cycle, so a
  // steady stream moves at one item per clock while the output is not stalled.
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  // Fault bits on the ports are FIELD_W wide. Bits beyond the mask width
  // are dropped, and a wider mask sees zeros in its upper bits.
  for (genvar i = 0; i < FaultBits; i++) begin : g_fault_in
    if (i < FIELD_W) begin : g_bit
      assign raise_w[i] = in_data.raise_faults[i];
      assign live_w[i]  = in_data.live_faults[i];
    end else begin : g_pad
      assign raise_w[i] = 1'b0;
      assign live_w[i]  = 1'b0;
    end
  end

  assign fault_empty = (fault_r == '0);

  // Event decode. A rejected event flags bad status and leaves every
  // state register as it was.
  always_comb begin
    mode_nxt  = mode_r;
    fault_nxt = fault_r;
    estop_nxt = estop_r;
    bad       = 1'b0;
    case (in_data.operation)
      OP_BOOT_DONE: begin
        if (mode_r == MODE_BOOT && fault_empty) begin
          mode_nxt = MODE_SAFE;
        end else begin
          bad = 1'b1;
        end
      end
      OP_ARM: begin
        if (mode_r == MODE_SAFE && fault_empty && !estop_r) begin
          mode_nxt = MODE_READY;
        end else begin
          bad = 1'b1;
        end
      end
      OP_DISARM: begin
        if (mode_r == MODE_SAFE || mode_r == MODE_READY || mode_r == MODE_RUNNING) begin
          mode_nxt = MODE_SAFE;
        end else begin
          bad = 1'b1;
        end
      end
      OP_MOTION_START: begin
        if (mode_r == MODE_READY || mode_r == MODE_RUNNING) begin
          mode_nxt = MODE_RUNNING;
        end else begin
          bad = 1'b1;
        end
      end
      OP_MOTION_STOP: begin
        // Stopping while already ready is harmless and reports ok.
        if (mode_r == MODE_RUNNING) begin
          mode_nxt = MODE_READY;
        end else if (mode_r != MODE_READY) begin
          bad = 1'b1;
        end
      end
      OP_RAISE_FAULT: begin
        // An empty fault set is a no-op; any bit forces the fault state.
        if (raise_w != '0) begin
          fault_nxt = fault_r | raise_w;
          mode_nxt  = MODE_FAULT;
        end
      end
      OP_ESTOP: begin
        estop_nxt = 1'b1;
        mode_nxt  = MODE_ESTOP;
      end
      OP_CLEAR: begin
        // Recovery only from fault or estop, and only with the hardware quiet.
        if ((mode_r == MODE_FAULT || mode_r == MODE_ESTOP) && live_w == '0) begin
          fault_nxt = '0;
          estop_nxt = 1'b0;
          mode_nxt  = MODE_SAFE;
        end else begin
          bad = 1'b1;
        end
      end
      default: begin
        bad = 1'b1;
      end
    endcase
  end

  // Only the low FIELD_W bits of the mask are visible on the result.
  for (genvar j = 0; j < FIELD_W; j++) begin : g_fault_out
    if (j < FaultBits) begin : g_bit
      assign faults_view[j] = fault_nxt[j];
    end else begin : g_pad
      assign faults_view[j] = 1'b0;
    end
  end

  assign armed = (mode_nxt == MODE_READY) || (mode_nxt == MODE_RUNNING);

  always_comb begin
    result.status         = bad ? STATUS_BAD : STATUS_OK;
    result.mode_now       = mode_code(mode_nxt);
    result.faults_now     = faults_view;
    result.estop_now      = estop_nxt;
    result.armed          = armed;
    result.motion_allowed = armed && (fault_nxt == '0) && !estop_nxt;
  end

  // The output register holds its item until the far side takes it; it is
  // refilled on every accepted event.
  always_comb begin
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_BOOT;
      fault_r     <= '0;
      estop_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        mode_r  <= mode_nxt;
        fault_r <= fault_nxt;
        estop_r <= estop_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // A set estop latch is only possible while in estop, or in fault after a
  // fault was raised on top of the stop.
  a_estop_mode: assert property (@(posedge clk) disable iff (!rst_n)
    estop_r |-> (mode_r == MODE_ESTOP || mode_r == MODE_FAULT))
    else $error("estop latch set outside fault and estop states");

  // Latched faults keep the machine in fault or estop until cleared.
  a_fault_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (fault_r != '0) |-> (mode_r == MODE_FAULT || mode_r == MODE_ESTOP))
    else $error("fault mask set outside fault and estop states");

  // Every accepted event shows a result in the next cycle.
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted event produced no result");

  // Motion is never allowed while faults or estop are latched.
  a_motion_safe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.motion_allowed) |->
      (out_data_r.faults_now == '0 && !out_data_r.estop_now && out_data_r.armed))
    else $error("motion allowed with faults or estop latched");
`endif

endmodule

>>> tb/msi_interlock_checker.sv
// ----------------------------------------------------------------------------
// msi_interlock_checker: result checker for the motion safety interlock.
// Predicts each result from accepted events and compares it in order.
// ----------------------------------------------------------------------------
module msi_interlock_checker
  import msi_pkg::*;
#(
  parameter int unsigned FaultBits = FAULT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  output int unsigned fail_count,
  output int unsigned pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Fault bits above the configured width are dropped on input.
  localparam logic [FIELD_W-1:0] FAULT_FIELD =
    (FaultBits >= FIELD_W) ? {FIELD_W{1'b1}} : FIELD_W'((1 << FaultBits) - 1);

  logic [2:0]         mode_now;
  logic [FIELD_W-1:0] fault_mask;
  logic               estop_latch;
  out_item_t          expected_results[$];
  out_item_t          want;
  int unsigned        mismatches = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Four-state compare, so an unknown bit on the result counts as a mismatch.
  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
    if (got !== exp_val) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, exp_val));
    end
  endtask

  // Applies one event to the shadow interlock and returns the snapshot.
  function automatic out_item_t interlock_step(input in_item_t ev);
    logic               rejected;
    logic [FIELD_W-1:0] raise;
    logic [FIELD_W-1:0] live;
    out_item_t          res;
    rejected = 1'b0;
    raise    = ev.raise_faults & FAULT_FIELD;
    live     = ev.live_faults & FAULT_FIELD;
    case (ev.operation)
      OP_BOOT_DONE: begin
        if (mode_now != MODE_CODE_BOOT || fault_mask != '0) rejected = 1'b1;
        else mode_now = MODE_CODE_SAFE;
      end
      OP_ARM: begin
        if (mode_now != MODE_CODE_SAFE || fault_mask != '0 || estop_latch) rejected = 1'b1;
        else mode_now = MODE_CODE_READY;
      end
      OP_DISARM: begin
        if (mode_now == MODE_CODE_SAFE || mode_now == MODE_CODE_READY ||
            mode_now == MODE_CODE_RUNNING) mode_now = MODE_CODE_SAFE;
        else rejected = 1'b1;
      end
      OP_MOTION_START: begin
        if (mode_now == MODE_CODE_READY || mode_now == MODE_CODE_RUNNING)
          mode_now = MODE_CODE_RUNNING;
        else rejected = 1'b1;
      end
      OP_MOTION_STOP: begin
        if (mode_now == MODE_CODE_RUNNING) mode_now = MODE_CODE_READY;
        else if (mode_now != MODE_CODE_READY) rejected = 1'b1;
      end
      OP_RAISE_FAULT: begin
        if (raise != '0) begin
          fault_mask = fault_mask | raise;
          mode_now   = MODE_CODE_FAULT;
        end
      end
      OP_ESTOP: begin
        estop_latch = 1'b1;
        mode_now    = MODE_CODE_ESTOP;
      end
      default: begin
        if ((mode_now != MODE_CODE_FAULT && mode_now != MODE_CODE_ESTOP) || live != '0) begin
          rejected = 1'b1;
        end else begin
          fault_mask  = '0;
          estop_latch = 1'b0;
          mode_now    = MODE_CODE_SAFE;
        end
      end
    endcase
    res.status         = rejected ? STATUS_BAD : STATUS_OK;
    res.mode_now       = mode_now;
    res.faults_now     = fault_mask;
    res.estop_now      = estop_latch;
    res.armed          = (mode_now == MODE_CODE_READY || mode_now == MODE_CODE_RUNNING);
    res.motion_allowed = res.armed && fault_mask == '0 && !estop_latch;
    return res;
  endfunction

  // Results are checked before new events are queued, since a result can
  // never belong to the event accepted at the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      mode_now    = MODE_CODE_BOOT;
      fault_mask  = '0;
      estop_latch = 1'b0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result arrived with no event outstanding");
        end else begin
          want = expected_results.pop_front();
          compare_field("status", out_data.status, want.status);
          compare_field("mode_now", out_data.mode_now, want.mode_now);
          compare_field("faults_now", out_data.faults_now, want.faults_now);
          compare_field("estop_now", out_data.estop_now, want.estop_now);
          compare_field("armed", out_data.armed, want.armed);
          compare_field("motion_allowed", out_data.motion_allowed, want.motion_allowed);
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(interlock_step(in_data));
    end
    pending_count <= expected_results.size();
  end

endmodule

>>> tb/tb_motion_safety_interlock_fsm_core.sv
// ----------------------------------------------------------------------------
// tb_motion_safety_interlock_fsm_core: testbench for the motion interlock.
// Drives a directed event walk through every state and several rejections, then a
// long run of weighted random events, with random gaps and output stalls.
// A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_motion_safety_interlock_fsm_core;
  import msi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // The cycle limit lies far beyond what the whole run needs.
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_EVENTS = 880;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned cycle_count = 0;

  // When set, neither side inserts gaps or stalls.
  logic        no_idle;

  motion_safety_interlock_fsm_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  msi_interlock_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The result side stalls about a quarter of the time, except in the
  // stretch where idling is switched off.
  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(0, 99) < 25);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic in_item_t make_event(input op_t op, input logic [FIELD_W-1:0] raise,
                                          input logic [FIELD_W-1:0] live);
    in_item_t ev;
    ev.operation    = op;
    ev.raise_faults = raise;
    ev.live_faults  = live;
    return ev;
  endfunction

  // Presents one item, possibly after idle gaps, and holds it until the block
  // takes it. Valid stays high straight into the next item unless a gap is
  // inserted, so it is never lowered and raised again within one edge.
  task automatic send_event(input in_item_t ev);
    while (!no_idle && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Picks an event with weights that keep the machine moving through
  // ready and running, while faults and emergency stops keep breaking in.
  function automatic in_item_t random_event();
    int unsigned        pick;
    op_t                op;
    logic [FIELD_W-1:0] raise;
    logic [FIELD_W-1:0] live;
    pick  = $urandom_range(0, 99);
    raise = FIELD_W'($urandom_range(0, 255));
    live  = FIELD_W'($urandom_range(0, 255));
    if (pick < 4)       op = OP_BOOT_DONE;
    else if (pick < 24) op = OP_ARM;
    else if (pick < 34) op = OP_DISARM;
    else if (pick < 54) op = OP_MOTION_START;
    else if (pick < 68) op = OP_MOTION_STOP;
    else if (pick < 78) op = OP_RAISE_FAULT;
    else if (pick < 86) op = OP_ESTOP;
    else                op = OP_CLEAR;
    // A raise with no bits is a no-op; give it a fair share.
    if (op == OP_RAISE_FAULT && $urandom_range(0, 99) < 20) raise = '0;
    // Most clears come with no live faults so that they actually succeed.
    if (op == OP_CLEAR && $urandom_range(0, 99) < 65) live = '0;
    return make_event(op, raise, live);
  endfunction

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    no_idle     <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk. In boot, stop, arm and clear are refused; an empty raise and boot completion pass.
    send_event(make_event(OP_MOTION_STOP, 8'h00, 8'h00));
    send_event(make_event(OP_ARM, 8'hFF, 8'hFF));
    send_event(make_event(OP_CLEAR, 8'h00, 8'h00));
    send_event(make_event(OP_RAISE_FAULT, 8'h00, 8'hFF));
    send_event(make_event(OP_BOOT_DONE, 8'h00, 8'h00));
    // Boot completion is a one-time event; motion is refused while safe.
    send_event(make_event(OP_BOOT_DONE, 8'h00, 8'h00));
    send_event(make_event(OP_MOTION_START, 8'h00, 8'h00));
    send_event(make_event(OP_MOTION_STOP, 8'h00, 8'h00));
    send_event(make_event(OP_DISARM, 8'h00, 8'h00));
    // Arm, then cycle between ready and running, including stop while ready
    // and start while already running.
    send_event(make_event(OP_ARM, 8'h00, 8'h00));
    send_event(make_event(OP_MOTION_STOP, 8'h00, 8'h00));
    send_event(make_event(OP_MOTION_START, 8'h00, 8'h00));
    send_event(make_event(OP_MOTION_START, 8'h00, 8'h00));
    send_event(make_event(OP_MOTION_STOP, 8'h00, 8'h00));
    send_event(make_event(OP_MOTION_START, 8'h00, 8'h00));
    send_event(make_event(OP_DISARM, 8'h00, 8'h00));
    send_event(make_event(OP_ARM, 8'h00, 8'h00));
    // Every fault bit at once, then a refused arm and a clear blocked by a
    // live fault on the top bit.
    send_event(make_event(OP_RAISE_FAULT, 8'hFF, 8'h00));
    send_event(make_event(OP_ARM, 8'h00, 8'h00));
    send_event(make_event(OP_CLEAR, 8'h00, 8'h80));
    // An emergency stop on top of latched faults, then a clean clear.
    send_event(make_event(OP_ESTOP, 8'h00, 8'h00));
    send_event(make_event(OP_CLEAR, 8'h00, 8'h00));
    // Emergency stop from safe blocks arming until cleared.
    send_event(make_event(OP_ESTOP, 8'h00, 8'h00));
    send_event(make_event(OP_ARM, 8'h00, 8'h00));
    send_event(make_event(OP_CLEAR, 8'h00, 8'h01));
    send_event(make_event(OP_CLEAR, 8'h00, 8'h00));

    // Random part, with one long stretch free of gaps and stalls.
    for (int unsigned n = 0; n < RANDOM_EVENTS; n++) begin
      if (n == 400) no_idle <= 1'b1;
      if (n == 560) no_idle <= 1'b0;
      send_event(random_event());
    end
    in_valid <= 1'b0;

    // The pending count first takes in the last accepted item, then the queue
    // drains, and a final wait lets any stray result show up.
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
